@@ hdl/ghcc_pkg.sv @@
// Shared types and constants for the greenhouse climate controller.
`default_nettype none

package ghcc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SEC_W    = 6;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 18;
    localparam int PCT_W    = 15;
    localparam int TEMP_W   = 19;
    localparam int SCALED_W = 17;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FAN_ON      = 3'd0;
    localparam logic [IDX_W-1:0] REG_FAN_OFF     = 3'd1;
    localparam logic [IDX_W-1:0] REG_PUMP_ON     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PUMP_OFF    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEMP_OFFSET = 3'd4;
    localparam logic [IDX_W-1:0] REG_DOOR_LIMIT  = 3'd5;

    localparam logic signed [17:0] FAN_ON_RST    = 18'sd7680;
    localparam logic signed [17:0] FAN_OFF_RST   = 18'sd6912;
    localparam logic [14:0]        PUMP_ON_RST   = 15'd7680;
    localparam logic [14:0]        PUMP_OFF_RST  = 15'd15360;
    localparam logic signed [15:0] OFFSET_RST    = 16'sd0;
    localparam logic [SEC_W-1:0]   DOOR_LIM_RST  = 6'd5;

    // Full-scale products of the scaling (percent and degrees, times 256)
    localparam int LIGHT_FULL = 25600;
    localparam int TEMP_FULL  = 128000;

    localparam logic [PCT_W-1:0] LIGHT_LOW  = 15'd1280;
    localparam logic [PCT_W-1:0] LIGHT_HIGH = 15'd15360;
    localparam logic [PCT_W-1:0] MOIST_LOW  = 15'd3840;
    localparam logic [PCT_W-1:0] MOIST_HIGH = 15'd23040;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = 19'sd3840;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 19'sd10240;

    localparam logic [PCT_W-1:0] CURTAIN_LOW  = 15'd2560;
    localparam logic [PCT_W-1:0] CURTAIN_HIGH = 15'd12800;
    localparam logic signed [TEMP_W-1:0] HEAT_LOW  = 19'sd5120;
    localparam logic signed [TEMP_W-1:0] HEAT_HIGH = 19'sd6400;
    localparam logic [15:0] HEAT_SPAN = 16'd2560;

    localparam logic [SEC_W-1:0] SEC_MAX  = 6'd59;
    localparam logic [SEC_W-1:0] SEC_WRAP = 6'd60;

    // Reciprocals for divide by 25 and by 5, exact for quotients of interest
    localparam int           RECIP_SHIFT = 24;
    localparam logic [19:0]  RECIP_25    = 20'd671089;
    localparam logic [21:0]  RECIP_5     = 22'd3355444;

    typedef struct packed {
        logic [PCT_W-1:0]  light;
        logic [PCT_W-1:0]  moisture;
        logic [TEMP_W-1:0] temp;
        logic              door;
        logic [SEC_W-1:0]  sec;
    } ghcc_scaled_t;

endpackage

`default_nettype wire

@@ hdl/greenhouse_climate_controller_top.sv @@
// Greenhouse climate controller: sensor scaling, fan/pump hysteresis, PWM duties and alarms.
`default_nettype none

// Takes one sampling item per clock while in_stall is low. The first stage scales the three ADC codes
// to percent and degrees (1/256 units) with the temperature offset applied; the
// second stage updates fan, pump, danger and door state and works out the
// curtain and heater duties. A taken item is held in the scaling register and its
// result is then registered in the output register; throughput is one item per
// cycle while out_stall is low, and the output register holds a stalled result
// while the scaling stage can still take one more item.
// Configuration writes are never held off (cfg_ready is always high) and
// are meant to be made while the block is idle.
module greenhouse_climate_controller_top #(
    parameter int ADC_BITS = 12,
    parameter int PWM_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ghcc_pkg::SAMPLE_W-1:0] light_sample,
    input  logic [ghcc_pkg::SAMPLE_W-1:0] moisture_sample,
    input  logic [ghcc_pkg::SAMPLE_W-1:0] temp_sample,
    input  logic                          door_open,
    input  logic [ghcc_pkg::SEC_W-1:0]    second,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          fan_on,
    output logic                          pump_on,
    output logic [PWM_BITS-1:0]           curtain_duty,
    output logic [PWM_BITS-1:0]           heater_duty,
    output logic                          light_danger,
    output logic                          moisture_danger,
    output logic                          temp_danger,
    output logic                          light_alarm,
    output logic                          moisture_alarm,
    output logic                          temp_alarm,
    output logic                          door_alarm,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ghcc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ghcc_pkg::CFG_W-1:0]    cfg_data
);
    import ghcc_pkg::*;

    localparam int FS     = (1 << ADC_BITS) - 1;
    localparam int CODE_W = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam logic [CODE_W-1:0]     FS_CODE = CODE_W'(FS);
    localparam logic [8:0]            LIGHT_Q = 9'(LIGHT_FULL / FS);
    localparam logic [ADC_BITS-1:0]   LIGHT_R = ADC_BITS'(LIGHT_FULL % FS);
    localparam logic [8:0]            TEMP_Q  = 9'(TEMP_FULL / FS);
    localparam logic [ADC_BITS-1:0]   TEMP_R  = ADC_BITS'(TEMP_FULL % FS);
    localparam logic [2*ADC_BITS-1:0] HALF_FS = (2*ADC_BITS)'(FS / 2);
    localparam logic [PWM_BITS-1:0]   PWM_FULL  = PWM_BITS'((1 << PWM_BITS) - 1);
    localparam logic [PWM_BITS-1:0]   PWM_TENTH = PWM_BITS'(((1 << PWM_BITS) - 1) / 10);
    localparam logic [PWM_BITS-1:0]   PWM_TWENTIETH = PWM_BITS'(((1 << PWM_BITS) - 1) / 20);

    function automatic logic [ADC_BITS-1:0] sat_code(input logic [SAMPLE_W-1:0] raw);
        logic [CODE_W-1:0] w;
        w = CODE_W'(raw);
        return (w > FS_CODE) ? FS_CODE[ADC_BITS-1:0] : w[ADC_BITS-1:0];
    endfunction

    // round(code * K / FS) with K = qk * FS + rk; FS = 2^n - 1 so the
    // remainder part folds into high half + low half and one compare.
    function automatic logic [SCALED_W-1:0] scale_code(input logic [ADC_BITS-1:0] code,
                                                       input logic [8:0]          qk,
                                                       input logic [ADC_BITS-1:0] rk);
        logic [2*ADC_BITS-1:0] y;
        logic [ADC_BITS:0]     s;
        logic [ADC_BITS+8:0]   p;
        logic                  carry;
        y = (2*ADC_BITS)'(code) * (2*ADC_BITS)'(rk) + HALF_FS;
        s = (ADC_BITS+1)'(y[2*ADC_BITS-1:ADC_BITS]) + (ADC_BITS+1)'(y[ADC_BITS-1:0]);
        carry = (s >= (ADC_BITS+1)'(FS));
        p = (ADC_BITS+9)'(code) * (ADC_BITS+9)'(qk);
        return SCALED_W'(p) + SCALED_W'(y[2*ADC_BITS-1:ADC_BITS]) + SCALED_W'(carry);
    endfunction

    // configuration
    logic signed [17:0] fan_on_reg;
    logic signed [17:0] fan_off_reg;
    logic [14:0]        pump_on_reg;
    logic [14:0]        pump_off_reg;
    logic signed [15:0] temp_offset_reg;
    logic [SEC_W-1:0]   door_limit_reg;

    // handshake and pipeline
    logic         s1_valid_reg, s1_valid_next;
    ghcc_scaled_t s1_reg, s1_next;
    logic         out_valid_reg, out_valid_next;
    logic         s1_adv, in_acc, upd;

    // control state
    logic             fan_reg, fan_next;
    logic             pump_reg, pump_next;
    logic [2:0]       prior_danger_reg, danger_next;
    logic             door_was_open_reg, door_was_open_next;
    logic [SEC_W-1:0] door_start_reg, door_start_next;

    // result register
    logic [PWM_BITS-1:0] curtain_reg, curtain_next;
    logic [PWM_BITS-1:0] heater_reg, heater_next;
    logic [2:0]          danger_out_reg;
    logic [2:0]          rise_reg, rise_next;
    logic                door_alarm_reg, door_alarm_next;

    // stage 1: scaling
    logic [SCALED_W-1:0]      light_scaled, moist_scaled, temp_scaled;
    logic signed [TEMP_W-1:0] temp_corr;

    always_comb
    begin
        light_scaled = scale_code(sat_code(light_sample), LIGHT_Q, LIGHT_R);
        moist_scaled = scale_code(sat_code(moisture_sample), LIGHT_Q, LIGHT_R);
        temp_scaled  = scale_code(sat_code(temp_sample), TEMP_Q, TEMP_R);
        temp_corr    = $signed({2'b00, temp_scaled}) - TEMP_W'(temp_offset_reg);
        s1_next.light    = light_scaled[PCT_W-1:0];
        s1_next.moisture = moist_scaled[PCT_W-1:0];
        s1_next.temp     = temp_corr;
        s1_next.door     = door_open;
        s1_next.sec      = (second > SEC_MAX) ? SEC_MAX : second;
    end

    assign s1_adv        = !out_valid_reg || !out_stall;
    assign in_stall      = s1_valid_reg && !s1_adv;
    assign in_acc        = in_valid && !in_stall;
    assign upd           = s1_valid_reg && s1_adv;
    assign s1_valid_next = in_acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = upd || (out_valid_reg && out_stall);

    // stage 2: control
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] fan_on_x, fan_off_x, heat_diff;
    logic [SEC_W-1:0]         start_sec, elapsed;
    logic [11:0]              cd;
    logic [PWM_BITS+11:0]     cp;
    logic [PWM_BITS+1:0]      cx;
    logic [PWM_BITS+23:0]     cq;
    logic [15:0]              he;
    logic [PWM_BITS+11:0]     hp;
    logic [PWM_BITS+2:0]      hx;
    logic [PWM_BITS+24:0]     hq;

    always_comb
    begin
        temp      = $signed(s1_reg.temp);
        fan_on_x  = TEMP_W'(fan_on_reg);
        fan_off_x = TEMP_W'(fan_off_reg);

        danger_next[0] = (s1_reg.light <= LIGHT_LOW) || (s1_reg.light >= LIGHT_HIGH);
        danger_next[1] = (s1_reg.moisture <= MOIST_LOW) || (s1_reg.moisture >= MOIST_HIGH);
        danger_next[2] = (temp <= TEMP_LOW) || (temp >= TEMP_HIGH);
        rise_next      = danger_next & ~prior_danger_reg;

        // turn-on test wins where the thresholds overlap
        priority if (temp >= fan_on_x)
            fan_next = 1'b1;
        else if (temp <= fan_off_x)
            fan_next = 1'b0;
        else
            fan_next = fan_reg;

        priority if (s1_reg.moisture <= pump_on_reg)
            pump_next = 1'b1;
        else if (s1_reg.moisture >= pump_off_reg)
            pump_next = 1'b0;
        else
            pump_next = pump_reg;

        // door timer, restarted after each alarm
        start_sec = door_was_open_reg ? door_start_reg : s1_reg.sec;
        elapsed   = (s1_reg.sec >= start_sec) ? s1_reg.sec - start_sec
                                              : SEC_WRAP - start_sec + s1_reg.sec;
        door_alarm_next    = s1_reg.door && (elapsed > door_limit_reg);
        door_was_open_next = s1_reg.door;
        if (!s1_reg.door)
            door_start_next = door_start_reg;
        else if (door_alarm_next)
            door_start_next = s1_reg.sec;
        else
            door_start_next = start_sec;

        // curtain: up to 2560, (2560 - L) * PF / 25600 = ((d * PF) >> 10) / 25; zero from 12800, a tenth between
        cd = 12'(CURTAIN_LOW - s1_reg.light);
        cp = {cd, {PWM_BITS{1'b0}}} - (PWM_BITS+12)'(cd);
        cx = cp[PWM_BITS+11:10];
        cq = (PWM_BITS+24)'(cx) * (PWM_BITS+24)'(RECIP_25);
        priority if (s1_reg.light <= CURTAIN_LOW)
            curtain_next = cq[RECIP_SHIFT +: PWM_BITS];
        else if (s1_reg.light >= CURTAIN_HIGH)
            curtain_next = '0;
        else
            curtain_next = PWM_TENTH;

        // heater: (5120 - T) * PF / 2560 = ((e * PF) >> 9) / 5, full scale once e >= 2560
        heat_diff = HEAT_LOW - temp;
        he = heat_diff[15:0];
        hp = {he[11:0], {PWM_BITS{1'b0}}} - (PWM_BITS+12)'(he[11:0]);
        hx = hp[PWM_BITS+11:9];
        hq = (PWM_BITS+25)'(hx) * (PWM_BITS+25)'(RECIP_5);
        priority if (temp < HEAT_LOW)
            heater_next = (he >= HEAT_SPAN) ? PWM_FULL : hq[RECIP_SHIFT +: PWM_BITS];
        else if (temp >= HEAT_HIGH)
            heater_next = '0;
        else
            heater_next = PWM_TWENTIETH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_on_reg        <= FAN_ON_RST;
            fan_off_reg       <= FAN_OFF_RST;
            pump_on_reg       <= PUMP_ON_RST;
            pump_off_reg      <= PUMP_OFF_RST;
            temp_offset_reg   <= OFFSET_RST;
            door_limit_reg    <= DOOR_LIM_RST;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            fan_reg           <= 1'b0;
            pump_reg          <= 1'b0;
            prior_danger_reg  <= 3'b000;
            door_was_open_reg <= 1'b0;
            door_start_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FAN_ON:      fan_on_reg      <= cfg_data;
                    REG_FAN_OFF:     fan_off_reg     <= cfg_data;
                    REG_PUMP_ON:     pump_on_reg     <= cfg_data[14:0];
                    REG_PUMP_OFF:    pump_off_reg    <= cfg_data[14:0];
                    REG_TEMP_OFFSET: temp_offset_reg <= cfg_data[15:0];
                    REG_DOOR_LIMIT:  door_limit_reg  <= cfg_data[SEC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (upd)
            begin
                fan_reg           <= fan_next;
                pump_reg          <= pump_next;
                prior_danger_reg  <= danger_next;
                door_was_open_reg <= door_was_open_next;
                door_start_reg    <= door_start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_reg <= s1_next;
        if (upd)
        begin
            curtain_reg    <= curtain_next;
            heater_reg     <= heater_next;
            danger_out_reg <= danger_next;
            rise_reg       <= rise_next;
            door_alarm_reg <= door_alarm_next;
        end
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign fan_on          = fan_reg;
    assign pump_on         = pump_reg;
    assign curtain_duty    = curtain_reg;
    assign heater_duty     = heater_reg;
    assign light_danger    = danger_out_reg[0];
    assign moisture_danger = danger_out_reg[1];
    assign temp_danger     = danger_out_reg[2];
    assign light_alarm     = rise_reg[0];
    assign moisture_alarm  = rise_reg[1];
    assign temp_alarm      = rise_reg[2];
    assign door_alarm      = door_alarm_reg;

    // an alarm pulse only comes with its band flagged
    a_alarm_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((rise_reg & ~danger_out_reg) == 3'b000))
        else $error("alarm without danger flag");

    // a scaled item moving on always lands in the result register
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv) |=> out_valid_reg)
        else $error("scaled item lost");

    // a shown door alarm comes from an item that left the door open
    a_door_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && door_alarm_reg) |-> door_was_open_reg)
        else $error("door alarm with door timer idle");

    // state is held while the result register is stalled
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(prior_danger_reg) && $stable(fan_reg))
        else $error("control state moved under stall");

endmodule

`default_nettype wire
